// File: sv/rmq_pkg.sv
package rmq_pkg;

    localparam int QONE = 16384;

    // Stage plan: input register, term select, square root, divide setup,
    // restoring divide, output register.
    localparam int SQ_BITS  = 15;
    localparam int DV_BITS  = 16;
    localparam int SQ_FIRST = 2;
    localparam int PREP     = SQ_FIRST + SQ_BITS;
    localparam int DV_FIRST = PREP + 1;
    localparam int LAST     = DV_FIRST + DV_BITS;

    typedef enum logic [1:0] {
        CASE_W = 2'd0,
        CASE_X = 2'd1,
        CASE_Y = 2'd2,
        CASE_Z = 2'd3
    } t_case;

    typedef logic [8:0][15:0] t_mat;

    // Lanes hold the three components that go through the divider, in
    // ascending component order with the root component left out.
    typedef struct packed {
        t_case            sel;
        logic [2:0]       neg;
        logic [2:0][29:0] num;
        logic [2:0][15:0] quo;
        logic [30:0]      sqn;
        logic [30:0]      sqr;
        logic [14:0]      root;
        logic [15:0]      den;
    } t_stg;

endpackage

// File: sv/rmq_div_step.sv
module rmq_div_step import rmq_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  logic [29:0] i_num,
    input  logic [15:0] i_den,
    output logic [29:0] o_num,
    output logic        o_bit
);
    logic [30:0] w_dsh;
    logic [30:0] w_num;

    assign w_dsh = 31'(i_den) << SHIFT;
    assign w_num = {1'b0, i_num};

    always_comb begin
        if (w_num >= w_dsh) begin
            o_bit = 1'b1;
            o_num = 30'(w_num - w_dsh);
        end else begin
            o_bit = 1'b0;
            o_num = i_num;
        end
    end
endmodule

// File: sv/rotation_matrix_to_quaternion.sv
// Channel | Direction | Handshake          | Payload
// input   | in        | i_valid / o_stall  | i_r00 .. i_r22, signed Q1.14
// output  | out       | o_valid / i_stall  | o_quat_w .. o_quat_z, o_largest_case
//
// One matrix per cycle is accepted while o_stall is low; an accepted item passes
// through 35 register stages to the output.
// The depth is set by the 15-stage square root and the 16-stage divider.
// Reset (synchronous, active low) clears all valid bits.
// A stall holds the output; earlier stages keep moving until they fill.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_r00,
    input  logic [15:0] i_r01,
    input  logic [15:0] i_r02,
    input  logic [15:0] i_r10,
    input  logic [15:0] i_r11,
    input  logic [15:0] i_r12,
    input  logic [15:0] i_r20,
    input  logic [15:0] i_r21,
    input  logic [15:0] i_r22,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_quat_w,
    output logic [15:0] o_quat_x,
    output logic [15:0] o_quat_y,
    output logic [15:0] o_quat_z,
    output logic [1:0]  o_largest_case
);
    logic [LAST:0] r_vld;
    logic [LAST:0] en;
    t_mat          r_m;
    t_stg          r_stg [1:LAST-1];
    logic [3:0][15:0] r_q;
    t_case         r_sel;

    function automatic logic signed [16:0] sx(input logic [15:0] v);
        return {v[15], v};
    endfunction

    // An empty stage, or one whose successor moves, may load.
    assign en[LAST] = !r_vld[LAST] || !i_stall;
    genvar k;
    for (k = 0; k < LAST; k++) begin : g_en
        assign en[k] = !r_vld[k] || en[k+1];
    end

    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 0; i <= LAST; i++) begin
                if (en[i]) begin
                    r_vld[i] <= (i == 0) ? i_valid : r_vld[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_m <= {i_r22, i_r21, i_r20, i_r12, i_r11, i_r10, i_r02, i_r01, i_r00};
        end
    end

    for (k = 1; k < LAST; k++) begin : g_stg
        t_stg n_s;
        if (k == 1) begin : g_sel
            logic signed [17:0] t0, t1, t2, t3, best;
            logic signed [16:0] d_a, d_b, d_c, d_p, d_q, d_r;
            logic signed [16:0] d [3];
            logic [16:0] bp;
            t_case sel;
            always_comb begin
                t0 = 18'(sx(r_m[0])) + 18'(sx(r_m[4])) + 18'(sx(r_m[8]));
                t1 = 18'(sx(r_m[0])) - 18'(sx(r_m[4])) - 18'(sx(r_m[8]));
                t2 = 18'(sx(r_m[4])) - 18'(sx(r_m[0])) - 18'(sx(r_m[8]));
                t3 = 18'(sx(r_m[8])) - 18'(sx(r_m[0])) - 18'(sx(r_m[4]));
                best = t0;
                sel  = CASE_W;
                if (t1 > best) begin
                    best = t1;
                    sel  = CASE_X;
                end
                if (t2 > best) begin
                    best = t2;
                    sel  = CASE_Y;
                end
                if (t3 > best) begin
                    best = t3;
                    sel  = CASE_Z;
                end
                // The four terms sum to zero, so the largest is never negative.
                bp  = best[16:0] + 17'(QONE);
                d_a = sx(r_m[5]) - sx(r_m[7]);
                d_b = sx(r_m[6]) - sx(r_m[2]);
                d_c = sx(r_m[1]) - sx(r_m[3]);
                d_p = sx(r_m[1]) + sx(r_m[3]);
                d_q = sx(r_m[6]) + sx(r_m[2]);
                d_r = sx(r_m[5]) + sx(r_m[7]);
                case (sel)
                    CASE_W: begin
                        d[0] = d_a; d[1] = d_b; d[2] = d_c;
                    end
                    CASE_X: begin
                        d[0] = d_a; d[1] = d_p; d[2] = d_q;
                    end
                    CASE_Y: begin
                        d[0] = d_b; d[1] = d_p; d[2] = d_r;
                    end
                    default: begin
                        d[0] = d_c; d[1] = d_q; d[2] = d_r;
                    end
                endcase
                n_s      = '0;
                n_s.sel  = sel;
                n_s.sqn  = {2'b00, bp, 12'b0};
                for (int i = 0; i < 3; i++) begin
                    n_s.neg[i] = d[i][16];
                    n_s.num[i] = 30'(d[i][16] ? 17'(-d[i]) : 17'(d[i]));
                end
            end
        end else if (k < PREP) begin : g_sqrt
            localparam int SH = 2 * (SQ_BITS - 1 - (k - SQ_FIRST));
            logic [30:0] bitv, trial;
            assign bitv  = 31'(1) << SH;
            assign trial = r_stg[k-1].sqr + bitv;
            always_comb begin
                n_s = r_stg[k-1];
                if (r_stg[k-1].sqn >= trial) begin
                    n_s.sqn = r_stg[k-1].sqn - trial;
                    n_s.sqr = (r_stg[k-1].sqr >> 1) + bitv;
                end else begin
                    n_s.sqr = r_stg[k-1].sqr >> 1;
                end
            end
        end else if (k == PREP) begin : g_prep
            logic [14:0] root;
            always_comb begin
                // Round to nearest: bump when the remainder exceeds the root.
                root = 15'(r_stg[k-1].sqr)
                       + ((r_stg[k-1].sqn > r_stg[k-1].sqr) ? 15'd1 : 15'd0);
                n_s      = r_stg[k-1];
                n_s.root = root;
                n_s.den  = {root, 1'b0};
                n_s.quo  = '0;
                for (int i = 0; i < 3; i++) begin
                    n_s.num[i] = {r_stg[k-1].num[i][16:0], 13'b0} + 30'(root);
                end
            end
        end else begin : g_div
            localparam int J = DV_BITS - 1 - (k - DV_FIRST);
            logic [2:0][29:0] num;
            logic [2:0]       qb;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                rmq_div_step #(.SHIFT(J)) u_step (
                    .i_num (r_stg[k-1].num[l]),
                    .i_den (r_stg[k-1].den),
                    .o_num (num[l]),
                    .o_bit (qb[l])
                );
            end
            always_comb begin
                n_s = r_stg[k-1];
                for (int i = 0; i < 3; i++) begin
                    n_s.num[i]    = num[i];
                    n_s.quo[i][J] = qb[i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_stg[k] <= n_s;
            end
        end
    end

    // Output stage: saturate, restore signs and place the lanes.
    t_stg             w_l;
    logic [15:0]      w_rv;
    logic [2:0][15:0] w_lane;
    logic [3:0][15:0] n_q;
    assign w_l = r_stg[LAST-1];

    always_comb begin
        w_rv = (w_l.root > 15'(QONE)) ? 16'(QONE) : {1'b0, w_l.root};
        for (int i = 0; i < 3; i++) begin
            w_lane[i] = (w_l.quo[i] > 16'(QONE)) ? 16'(QONE) : w_l.quo[i];
            if (w_l.neg[i]) begin
                w_lane[i] = 16'(-w_lane[i]);
            end
        end
        case (w_l.sel)
            CASE_W:  n_q = {w_lane[2], w_lane[1], w_lane[0], w_rv};
            CASE_X:  n_q = {w_lane[2], w_lane[1], w_rv, w_lane[0]};
            CASE_Y:  n_q = {w_lane[2], w_rv, w_lane[1], w_lane[0]};
            default: n_q = {w_rv, w_lane[2], w_lane[1], w_lane[0]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[LAST]) begin
            r_q   <= n_q;
            r_sel <= w_l.sel;
        end
    end

    assign o_valid        = r_vld[LAST];
    assign o_quat_w       = r_q[0];
    assign o_quat_x       = r_q[1];
    assign o_quat_y       = r_q[2];
    assign o_quat_z       = r_q[3];
    assign o_largest_case = r_sel;
endmodule

// File: sv/rmq_checker.sv
module rmq_assert import rmq_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_quat_w,
    input logic [15:0] o_quat_x,
    input logic [15:0] o_quat_y,
    input logic [15:0] o_quat_z,
    input logic [1:0]  o_largest_case
);
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_quat_w) && $stable(o_quat_x)
            && $stable(o_quat_y) && $stable(o_quat_z) && $stable(o_largest_case))
        else $error("stalled item changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $signed(o_quat_w) >= -QONE && $signed(o_quat_w) <= QONE
            && $signed(o_quat_x) >= -QONE && $signed(o_quat_x) <= QONE
            && $signed(o_quat_y) >= -QONE && $signed(o_quat_y) <= QONE
            && $signed(o_quat_z) >= -QONE && $signed(o_quat_z) <= QONE)
        else $error("component out of range");

    // The root component is at least one half.
    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_largest_case == CASE_W && $signed(o_quat_w) >= QONE / 2)
            || (o_largest_case == CASE_X && $signed(o_quat_x) >= QONE / 2)
            || (o_largest_case == CASE_Y && $signed(o_quat_y) >= QONE / 2)
            || (o_largest_case == CASE_Z && $signed(o_quat_z) >= QONE / 2))
        else $error("root component below one half");
endmodule

bind rotation_matrix_to_quaternion rmq_assert u_rmq_assert (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_quat_w       (o_quat_w),
    .o_quat_x       (o_quat_x),
    .o_quat_y       (o_quat_y),
    .o_quat_z       (o_quat_z),
    .o_largest_case (o_largest_case)
);
